### sv/isomsq_pkg.sv
// Shared widths, constants and controller/datapath command types.
`default_nettype none
package isomsq_pkg;

  localparam int ARG_W         = 16;
  localparam int MAG_W         = 15;
  localparam int X2_W          = 30;
  localparam int TERM_W        = 32;
  localparam int ACC_W         = 48;
  localparam int ACC_FRAC      = 32;
  localparam int OUT_W         = 32;
  localparam int TOL_W         = 17;
  localparam int TOL_SHIFT     = 16;
  localparam int CNT_OUT_W     = 9;
  localparam int DIVD_W        = TERM_W + 1;

  localparam int MAX_TERMS_DEF     = 256;
  localparam int SUM_FRAC_BITS_DEF = 16;

  localparam logic [TOL_W-1:0] TOL_RESET   = 17'd66;
  localparam logic [ARG_W-1:0] ARG_INVALID = 16'h8000;

  // Commands issued by the controller, at most one per cycle.
  typedef struct packed {
    logic load;       // capture the argument
    logic square;     // x2 = |x| * |x|
    logic first;      // first term x^2/2, sum = 1 + term, count = 1
    logic mul;        // p = (term * x2) >> 30
    logic div_start;  // launch ceil(p / 2k)
    logic update;     // term = p - ceil(p / 2k), accumulate, count++
    logic out_load;   // register the result transaction
  } cmd_t;

  // Status reported by the datapath.
  typedef struct packed {
    logic arg_invalid;
    logic more_terms;
    logic div_done;
  } stat_t;

endpackage
`default_nettype wire

### sv/isomsq_ifs.sv
// Valid/ready channel interfaces for the argument and the result.
`default_nettype none
interface isomsq_in_if;
  import isomsq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [ARG_W-1:0] arg_x;
  modport source (output valid, output arg_x, input ready);
  modport sink   (input valid, input arg_x, output ready);
endinterface

interface isomsq_out_if;
  import isomsq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OUT_W-1:0]     series_sum;
  logic [CNT_OUT_W-1:0] terms_added;
  logic                 sum_saturated;
  logic                 limit_reached;
  logic                 input_invalid;
  modport source (output valid, output series_sum, output terms_added,
                  output sum_saturated, output limit_reached,
                  output input_invalid, input ready);
  modport sink   (input valid, input series_sum, input terms_added,
                  input sum_saturated, input limit_reached,
                  input input_invalid, output ready);
endinterface
`default_nettype wire

### sv/isomsq_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module isomsq_div
  import isomsq_pkg::*;
#(
  parameter int D_W = 10
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIVD_W-1:0] dividend,
  input  wire logic [D_W-1:0]    divisor,
  output logic      [DIVD_W-1:0] quotient,
  output logic                   done
);

  localparam int CW = $clog2(DIVD_W + 1);

  logic [D_W-1:0]    rem_r, rem_nxt;
  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [D_W-1:0]    dsr_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [D_W:0]      trial;
  logic              fit;

  always_comb begin
    trial    = {rem_r, quo_r[DIVD_W-1]};
    fit      = trial >= {1'b0, dsr_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = done_r;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CW'(DIVD_W);
      done_nxt = 1'b0;
    end else if (cnt_r != '0) begin
      rem_nxt = fit ? D_W'(trial - {1'b0, dsr_r}) : trial[D_W-1:0];
      quo_nxt = {quo_r[DIVD_W-2:0], fit};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule
`default_nettype wire

### sv/isomsq_dp.sv
// Datapath: argument square, term recurrence, saturating sum and result register.
`default_nettype none
module isomsq_dp
  import isomsq_pkg::*;
#(
  parameter int MAX_TERMS     = MAX_TERMS_DEF,
  parameter int SUM_FRAC_BITS = SUM_FRAC_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [TOL_W-1:0]        cfg_wdata,
  input  wire logic signed [ARG_W-1:0] arg_x,
  input  wire cmd_t                    cmd,
  output stat_t                        stat,
  output logic [OUT_W-1:0]             series_sum,
  output logic [CNT_OUT_W-1:0]         terms_added,
  output logic                         sum_saturated,
  output logic                         limit_reached,
  output logic                         input_invalid
);

  localparam int CNT_BITS  = $clog2(MAX_TERMS + 1);
  localparam int CNT_W     = (CNT_BITS > CNT_OUT_W) ? CNT_BITS : CNT_OUT_W;
  localparam int D_W       = CNT_W + 1;
  localparam int OUT_SHIFT = ACC_FRAC - SUM_FRAC_BITS;
  localparam int PROD_W    = TERM_W + X2_W;
  localparam int CMP_W     = TOL_W + TOL_SHIFT;

  logic [TOL_W-1:0]  tol_r;
  logic [MAG_W-1:0]  mag_r;
  logic              inv_r;
  logic [X2_W-1:0]   x2_r;
  logic [TERM_W-1:0] term_r, p_r, term_new;
  logic [ACC_W-1:0]  sum_r;
  logic [CNT_W-1:0]  count_r;
  logic [ARG_W-1:0]  arg_abs;
  logic [PROD_W-1:0] prod;
  logic [D_W-1:0]    two_k;
  logic [DIVD_W-1:0] dividend, quotient;
  logic              div_done;
  logic [ACC_W:0]    sum_ext;
  logic [ACC_W-1:0]  sum_shifted;
  logic              term_gt_tol;
  logic              out_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // The next term is floor(p * (2k-1) / 2k), which equals p - ceil(p / 2k).
  always_comb begin
    arg_abs     = arg_x[ARG_W-1] ? ARG_W'(-arg_x) : arg_x;
    prod        = PROD_W'(term_r) * PROD_W'(x2_r);
    two_k       = {CNT_W'(count_r + 1'b1), 1'b0};
    dividend    = {1'b0, p_r} + DIVD_W'(two_k) - DIVD_W'(1);
    term_new    = p_r - quotient[TERM_W-1:0];
    sum_ext     = {1'b0, sum_r} + (ACC_W + 1)'(term_new);
    term_gt_tol = CMP_W'(term_r) > {tol_r, {TOL_SHIFT{1'b0}}};
    sum_shifted = sum_r >> OUT_SHIFT;
    out_sat     = |sum_shifted[ACC_W-1:OUT_W];
  end

  isomsq_div #(.D_W(D_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (two_k),
    .quotient (quotient),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r <= arg_abs[MAG_W-1:0];
      inv_r <= arg_x == ARG_INVALID;
    end
    if (cmd.square) begin
      x2_r <= X2_W'(mag_r * mag_r);
    end
    if (cmd.first) begin
      term_r  <= {1'b0, x2_r, 1'b0};
      sum_r   <= (ACC_W'(1) << ACC_FRAC) + ACC_W'({x2_r, 1'b0});
      count_r <= CNT_W'(1);
    end
    if (cmd.mul) begin
      p_r <= prod[PROD_W-1:X2_W];
    end
    if (cmd.update) begin
      term_r  <= term_new;
      sum_r   <= sum_ext[ACC_W] ? {ACC_W{1'b1}} : sum_ext[ACC_W-1:0];
      count_r <= count_r + 1'b1;
    end
    if (cmd.out_load) begin
      if (inv_r) begin
        series_sum    <= '0;
        terms_added   <= '0;
        sum_saturated <= 1'b0;
        limit_reached <= 1'b0;
        input_invalid <= 1'b1;
      end else begin
        series_sum    <= out_sat ? {OUT_W{1'b1}} : sum_shifted[OUT_W-1:0];
        terms_added   <= count_r[CNT_OUT_W-1:0];
        sum_saturated <= out_sat;
        limit_reached <= term_gt_tol;
        input_invalid <= 1'b0;
      end
    end
  end

  assign stat.arg_invalid = inv_r;
  assign stat.more_terms  = term_gt_tol && (count_r < CNT_W'(MAX_TERMS));
  assign stat.div_done    = div_done;

endmodule
`default_nettype wire

### sv/isomsq_ctrl.sv
// Controller: sequences one series per transaction and owns both handshakes.
`default_nettype none
module isomsq_ctrl
  import isomsq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQ    = 4'd1;
  localparam logic [3:0] S_FIRST = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_DIVS  = 4'd5;
  localparam logic [3:0] S_DIVW  = 4'd6;
  localparam logic [3:0] S_UPD   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    slot_free = !out_valid_r || out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.square = 1'b1;
        state_nxt  = stat.arg_invalid ? S_DONE : S_FIRST;
      end
      S_FIRST: begin
        cmd.first = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = stat.more_terms ? S_MUL : S_DONE;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIVS;
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVW;
      end
      S_DIVW: begin
        if (stat.div_done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_CHECK;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

### sv/inv_sqrt_one_minus_sq_series_core.sv
// Top level of the Maclaurin series evaluator for 1/sqrt(1 - x^2).
//
// The input channel in_ch carries one signed Q1.15 argument per transaction.
// The result channel out_ch returns one transaction per argument: the sum in
// unsigned fixed point with SUM_FRAC_BITS fraction bits, the number of terms
// added after the leading 1, and the saturation, term limit and invalid flags.
// The user must write the tolerance register through cfg_we/cfg_wdata only while
// idle; the block does not enforce this. An argument is taken only when the
// sequencer is idle. Each term after the first costs one 32x30 multiply and a
// 33-step bit-serial division by 2k on the shared divider, so the count of
// terms, set by x, the tolerance and MAX_TERMS, rules the throughput.
// An argument of -1 is flagged invalid.
// The result sits in an output register; the next argument is accepted while
// it waits, and a stalled receiver only holds the sequencer at its final step.
// A synchronous reset (rst_n low) returns the sequencer to idle, drops
// out_ch.valid and reloads the tolerance with its reset value.
`default_nettype none
module inv_sqrt_one_minus_sq_series_core
  import isomsq_pkg::*;
#(
  parameter int MAX_TERMS     = MAX_TERMS_DEF,
  parameter int SUM_FRAC_BITS = SUM_FRAC_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  isomsq_in_if.sink             in_ch,
  isomsq_out_if.source          out_ch,
  input  wire logic             cfg_we,
  input  wire logic [TOL_W-1:0] cfg_wdata
);

  // Command and status bundles between the sequencer and the datapath.
  cmd_t  cmd;
  stat_t stat;

  isomsq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  isomsq_dp #(
    .MAX_TERMS     (MAX_TERMS),
    .SUM_FRAC_BITS (SUM_FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .arg_x         (in_ch.arg_x),
    .cmd           (cmd),
    .stat          (stat),
    .series_sum    (out_ch.series_sum),
    .terms_added   (out_ch.terms_added),
    .sum_saturated (out_ch.sum_saturated),
    .limit_reached (out_ch.limit_reached),
    .input_invalid (out_ch.input_invalid)
  );

endmodule
`default_nettype wire

### sv/isomsq_chk.sv
// Port-level checker for the series evaluator and its bind to the top level.
`default_nettype none
module isomsq_chk
  import isomsq_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [OUT_W-1:0]     series_sum,
  input wire logic [CNT_OUT_W-1:0] terms_added,
  input wire logic                 sum_saturated,
  input wire logic                 limit_reached,
  input wire logic                 input_invalid
);

  // An invalid argument returns all other fields cleared.
  a_invalid_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && input_invalid |->
      series_sum == '0 && terms_added == '0 && !sum_saturated && !limit_reached)
    else $error("invalid result carries nonzero fields");

  // A saturated sum is pinned at full scale.
  a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && sum_saturated |-> series_sum == {OUT_W{1'b1}})
    else $error("saturated sum below full scale");

  // One argument at a time: the sequencer is busy right after a transaction.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("argument accepted in back-to-back cycles");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(series_sum)
      && $stable(terms_added))
    else $error("stalled result changed");

endmodule

bind inv_sqrt_one_minus_sq_series_core isomsq_chk u_isomsq_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .series_sum    (out_ch.series_sum),
  .terms_added   (out_ch.terms_added),
  .sum_saturated (out_ch.sum_saturated),
  .limit_reached (out_ch.limit_reached),
  .input_invalid (out_ch.input_invalid)
);
`default_nettype wire
